### rtl/core/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// shared constants, request/response types and block-table entry format for
// the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

  // heap geometry
  localparam int HEAP_BYTES   = 32768;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_BLOCKS   = 64;

  // field widths
  localparam int ADDR_W = 15;
  localparam int LINK_W = 7;
  localparam int SLOT_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  // chain terminator
  localparam logic [LINK_W-1:0] END_MARK = {LINK_W{1'b1}};

  // slot 0 size after reset
  localparam logic [ADDR_W-1:0] INIT_SIZE = ADDR_W'(HEAP_BYTES - HEADER_BYTES);

  // request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_e;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] request_bytes;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] granted_address;
    logic [ADDR_W-1:0] freed_bytes;
  } rsp_t;

  // one block-table row
  typedef struct packed {
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] size;
    logic              used;
    logic [LINK_W-1:0] next;
  } entry_t;

  localparam entry_t INIT_ENTRY = '{
    offset: '0,
    size:   INIT_SIZE,
    used:   1'b0,
    next:   END_MARK
  };

  // sequencer to table port
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    entry_t            wr_entry;
  } tbl_req_t;

  // fit unit verdicts
  typedef struct packed {
    logic              exact;
    logic              split;
    logic              match;
    logic [ADDR_W-1:0] tail_offset;
    logic [ADDR_W-1:0] tail_size;
  } fit_t;

endpackage

### rtl/core/ffba_table.sv
// ----------------------------------------------------------------------------
// ffba_table
// block-table memory: one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ffba_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffba_pkg::tbl_req_t  req_i,
  output ffba_pkg::entry_t    rd_entry_o
);

  ffba_pkg::entry_t mem_q [ffba_pkg::MAX_BLOCKS];
  ffba_pkg::entry_t rd_q;
  logic             slot0_vld_q;
  logic             rd_init_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_slot] <= req_i.wr_entry;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_slot];
    end
  end

  // slot 0 reads as its reset row until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot0_vld_q <= 1'b0;
      rd_init_q   <= 1'b0;
    end else begin
      if (req_i.wr_en && (req_i.wr_slot == '0)) begin
        slot0_vld_q <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_init_q <= (req_i.rd_slot == '0) && !slot0_vld_q;
      end
    end
  end

  assign rd_entry_o = rd_init_q ? ffba_pkg::INIT_ENTRY : rd_q;

endmodule

### rtl/core/ffba_fit.sv
// ----------------------------------------------------------------------------
// ffba_fit
// shared compare/add unit: fit tests and split arithmetic for one table row
// ----------------------------------------------------------------------------
module ffba_fit (
  input  ffba_pkg::entry_t                 entry_i,
  input  logic [ffba_pkg::ADDR_W-1:0]      demand_i,
  input  logic [ffba_pkg::ADDR_W-1:0]      addr_i,
  output ffba_pkg::fit_t                   fit_o
);

  logic [ffba_pkg::ADDR_W:0] need;

  // demand plus one header, one bit wider
  assign need = {1'b0, demand_i} + (ffba_pkg::ADDR_W+1)'(ffba_pkg::HEADER_BYTES);

  assign fit_o.exact       = (entry_i.size == demand_i);
  assign fit_o.split       = ({1'b0, entry_i.size} > need);
  assign fit_o.match       = (entry_i.offset == addr_i);
  assign fit_o.tail_offset = entry_i.offset + need[ffba_pkg::ADDR_W-1:0];
  assign fit_o.tail_size   = entry_i.size - need[ffba_pkg::ADDR_W-1:0];

endmodule

### rtl/core/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit heap allocator with block split, table-driven, one request at a time
// ----------------------------------------------------------------------------
// latency grows with the walk: allocate reads and evaluates each chain block
//   visited, plus a link step on a split, and stops after MAX_BLOCKS blocks;
//   free reads and evaluates slots in turn until one matches the address
// the table's registered read splits each walk step into S_READ and S_EVAL
// one request at a time: start is taken only in idle; busy is high until done
// done_o strobes for exactly one cycle, rsp_o holds; the receiver cannot stall
// reset: asynchronous active low; heap returns to one free block, no clear pass
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ffba_pkg::req_t   req_i,
  output logic             done_o,
  output ffba_pkg::rsp_t   rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_LINK
  } state_e;

  state_e                           state_q, state_d;
  logic                             mode_q, mode_d;
  logic [ffba_pkg::ADDR_W-1:0]      demand_q, demand_d;
  logic [ffba_pkg::ADDR_W-1:0]      addr_q, addr_d;
  logic [ffba_pkg::LINK_W-1:0]      cur_q, cur_d;     // walk pointer / scan index
  logic [ffba_pkg::LINK_W-1:0]      steps_q, steps_d; // blocks visited
  logic [ffba_pkg::LINK_W-1:0]      slots_q, slots_d; // slots in use
  ffba_pkg::entry_t                 link_q, link_d;   // head row of a split
  logic                             done_q, done_d;
  ffba_pkg::rsp_t                   rsp_q, rsp_d;

  ffba_pkg::tbl_req_t               tbl_req;
  ffba_pkg::entry_t                 row;
  ffba_pkg::fit_t                   fit;
  logic                             in_range;

  ffba_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (tbl_req),
    .rd_entry_o (row)
  );

  ffba_fit u_fit (
    .entry_i  (row),
    .demand_i (demand_q),
    .addr_i   (addr_q),
    .fit_o    (fit)
  );

  // a link past the filled slots (or the end mark) ends the walk
  assign in_range = (cur_q < slots_q);

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    demand_d = demand_q;
    addr_d   = addr_q;
    cur_d    = cur_q;
    steps_d  = steps_q;
    slots_d  = slots_q;
    link_d   = link_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    tbl_req  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          mode_d   = req_i.mode;
          demand_d = req_i.request_bytes;
          addr_d   = req_i.block_address;
          cur_d    = '0;
          steps_d  = '0;
          state_d  = S_READ;
        end
      end

      S_READ: begin
        if (!in_range ||
            ((mode_q == ffba_pkg::MODE_ALLOC) &&
             (steps_q == ffba_pkg::LINK_W'(ffba_pkg::MAX_BLOCKS)))) begin
          // walk ran out: no fit for allocate, unknown header for free
          rsp_d.status          = (mode_q == ffba_pkg::MODE_ALLOC) ?
                                  ffba_pkg::ST_NO_FIT : ffba_pkg::ST_BAD_ADDR;
          rsp_d.granted_address = '0;
          rsp_d.freed_bytes     = '0;
          done_d                = 1'b1;
          state_d               = S_IDLE;
        end else begin
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_slot = cur_q[ffba_pkg::SLOT_W-1:0];
          state_d         = S_EVAL;
        end
      end

      S_EVAL: begin
        if (mode_q == ffba_pkg::MODE_ALLOC) begin
          if (!row.used && fit.exact) begin
            // exact fit: mark used in place
            tbl_req.wr_en         = 1'b1;
            tbl_req.wr_slot       = cur_q[ffba_pkg::SLOT_W-1:0];
            tbl_req.wr_entry      = row;
            tbl_req.wr_entry.used = 1'b1;
            rsp_d.status          = ffba_pkg::ST_OK;
            rsp_d.granted_address = row.offset;
            rsp_d.freed_bytes     = '0;
            done_d                = 1'b1;
            state_d               = S_IDLE;
          end else if (!row.used && fit.split &&
                       (slots_q < ffba_pkg::LINK_W'(ffba_pkg::MAX_BLOCKS))) begin
            // split: tail goes to a fresh slot now, head is relinked next cycle
            tbl_req.wr_en                = 1'b1;
            tbl_req.wr_slot              = slots_q[ffba_pkg::SLOT_W-1:0];
            tbl_req.wr_entry.offset      = fit.tail_offset;
            tbl_req.wr_entry.size        = fit.tail_size;
            tbl_req.wr_entry.used        = 1'b0;
            tbl_req.wr_entry.next        = row.next;
            link_d.offset                = row.offset;
            link_d.size                  = demand_q;
            link_d.used                  = 1'b1;
            link_d.next                  = slots_q;
            slots_d                      = slots_q + 1'b1;
            rsp_d.status                 = ffba_pkg::ST_OK;
            rsp_d.granted_address        = row.offset;
            rsp_d.freed_bytes            = '0;
            state_d                      = S_LINK;
          end else begin
            cur_d   = row.next;
            steps_d = steps_q + 1'b1;
            state_d = S_READ;
          end
        end else begin
          if (fit.match) begin
            // free: no coalescing, double free reports the size again
            tbl_req.wr_en         = 1'b1;
            tbl_req.wr_slot       = cur_q[ffba_pkg::SLOT_W-1:0];
            tbl_req.wr_entry      = row;
            tbl_req.wr_entry.used = 1'b0;
            rsp_d.status          = ffba_pkg::ST_OK;
            rsp_d.granted_address = '0;
            rsp_d.freed_bytes     = row.size;
            done_d                = 1'b1;
            state_d               = S_IDLE;
          end else begin
            cur_d   = cur_q + 1'b1;
            state_d = S_READ;
          end
        end
      end

      S_LINK: begin
        tbl_req.wr_en    = 1'b1;
        tbl_req.wr_slot  = cur_q[ffba_pkg::SLOT_W-1:0];
        tbl_req.wr_entry = link_q;
        done_d           = 1'b1;
        state_d          = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= ffba_pkg::MODE_ALLOC;
      demand_q <= '0;
      addr_q   <= '0;
      cur_q    <= '0;
      steps_q  <= '0;
      slots_q  <= ffba_pkg::LINK_W'(1);
      link_q   <= '0;
      done_q   <= 1'b0;
      rsp_q    <= '0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      demand_q <= demand_d;
      addr_q   <= addr_d;
      cur_q    <= cur_d;
      steps_q  <= steps_d;
      slots_q  <= slots_d;
      link_q   <= link_d;
      done_q   <= done_d;
      rsp_q    <= rsp_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // a result only ever closes a request that was in flight
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("done without a request in flight");

  // the table holds at least the first block and never more than its slots
  a_slots_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slots_q != '0) && (slots_q <= ffba_pkg::LINK_W'(ffba_pkg::MAX_BLOCKS)))
    else $error("slot count out of range");

  // read and write of the table never share a cycle
  a_tbl_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tbl_req.rd_en && tbl_req.wr_en))
    else $error("table read and write collide");

  // an accepted request always makes the block busy next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request not taken up");

  // a split grows the table by exactly one slot
  a_split_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK) |-> (slots_q == $past(slots_q) + 1'b1))
    else $error("split did not claim one slot");

endmodule
